// ----- hdl/ssfl_pkg.sv -----
// Shared types, register codes and the case fold for the substring search block.
// No dependencies; imported by ssfl_cell and substring_search_first_last_core.
package ssfl_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned LenW    = 4;
  localparam int unsigned IndexW  = 16;
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 64;

  // Register select: paddr[4:3], registers sit on 8-byte boundaries.
  typedef enum logic [1:0] {
    REG_PATTERN_CHARS  = 2'd0,
    REG_PATTERN_LENGTH = 2'd1,
    REG_IGNORE_CASE    = 2'd2,
    REG_SEARCH_LAST    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [CharW-1:0] text_byte;
    logic             last_byte;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [IndexW-1:0] match_index;
    logic              overflow;
  } out_item_t;

  // Per-cycle control broadcast to every cell.
  typedef struct packed {
    logic advance;      // byte accepted and compared
    logic clear;        // end of text, drop partial matches
    logic ignore_case;
  } cell_ctrl_t;

  // ASCII A..Z to a..z when folding is on.
  function automatic logic [CharW-1:0] fold(input logic [CharW-1:0] c, input logic ic);
    logic [CharW-1:0] r;
    r = c;
    if (ic && c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// ----- hdl/ssfl_cell.sv -----
// One shift-and cell: holds the partial match bit for one pattern position.
// Depends on ssfl_pkg (cell_ctrl_t, fold).
module ssfl_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ssfl_pkg::cell_ctrl_t   ctrl_i,
  input  logic [7:0]             text_i,     // already folded
  input  logic [7:0]             pat_byte_i,
  input  logic                   enable_i,   // position is inside the pattern
  input  logic                   prev_i,     // neighbor's held bit
  output logic                   hit_d_o,
  output logic                   hit_q_o
);
  import ssfl_pkg::*;

  logic hit_d, hit_q;

  assign hit_d = prev_i & enable_i & (fold(pat_byte_i, ctrl_i.ignore_case) == text_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      hit_q <= 1'b0;
    end else if (ctrl_i.advance) begin
      hit_q <= hit_d;
    end
  end

  assign hit_d_o = hit_d;
  assign hit_q_o = hit_q;

endmodule

// ----- hdl/substring_search_first_last_core.sv -----
// Top level of the streaming substring search (first or last occurrence).
// Depends on ssfl_pkg and ssfl_cell.
//
//  channel   | handshake                     | payload
//  ----------+-------------------------------+------------------------------------
//  in        | in_valid_i / in_ready_o       | in_data_i  : text_byte, last_byte
//  out       | out_valid_o / out_ready_i     | out_data_o : found, match_index,
//            |                               |              overflow
//  config    | psel, penable, pwrite, pready | paddr, pwdata, prdata (64 bit)
//
// One byte per cycle while the input is not stalled: every byte is compared in all cells at once, and the
// partial match bits advance one cell per accepted byte.
// A last byte's item is loaded into the output register at the clock edge that accepts the byte.
// Input stalls only while the output register is full and not being taken.
// Reset clears the cells, text counters and output valid; registers go to
// pattern 0, length 1, case folding and last-search off.
module substring_search_first_last_core #(
  parameter int unsigned PATTERN_MAX = 8,     // 1..8 cells
  parameter int unsigned TEXT_MAX    = 65536  // 2..65536 compared bytes
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // byte stream
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ssfl_pkg::in_item_t                  in_data_i,
  // result stream
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ssfl_pkg::out_item_t                 out_data_o,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ssfl_pkg::CfgAddrW-1:0]       paddr,
  input  logic [ssfl_pkg::CfgDataW-1:0]       pwdata,
  output logic [ssfl_pkg::CfgDataW-1:0]       prdata,
  output logic                                pready
);
  import ssfl_pkg::*;

  // Position counter saturates at TEXT_MAX, so it must hold TEXT_MAX itself.
  localparam int unsigned PosW = $clog2(TEXT_MAX + 1);
  localparam logic [PosW-1:0] TextMaxP = PosW'(TEXT_MAX);

  // ---------------------------------------------------------------- config
  logic [63:0]     pattern_q;
  logic [LenW-1:0] length_q;
  logic            icase_q;
  logic            slast_q;
  logic            cfg_wr;
  cfg_reg_e        cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[4:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      length_q  <= LenW'(1);
      icase_q   <= 1'b0;
      slast_q   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_PATTERN_CHARS:  pattern_q <= pwdata;
        REG_PATTERN_LENGTH: length_q  <= pwdata[LenW-1:0];
        REG_IGNORE_CASE:    icase_q   <= pwdata[0];
        REG_SEARCH_LAST:    slast_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_PATTERN_CHARS:  prdata = pattern_q;
      REG_PATTERN_LENGTH: prdata = CfgDataW'(length_q);
      REG_IGNORE_CASE:    prdata = CfgDataW'(icase_q);
      REG_SEARCH_LAST:    prdata = CfgDataW'(slast_q);
      default:            prdata = '0;
    endcase
  end

  // Pattern length in use: zero counts as one, clamp to the cell count.
  logic [LenW-1:0] len_eff;
  always_comb begin
    if (length_q == '0) begin
      len_eff = LenW'(1);
    end else if (length_q > LenW'(PATTERN_MAX)) begin
      len_eff = LenW'(PATTERN_MAX);
    end else begin
      len_eff = length_q;
    end
  end

  // ---------------------------------------------------------------- handshake
  logic out_valid_q;
  out_item_t out_data_q;
  logic in_fire;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_fire    = in_valid_i & in_ready_o;

  // ---------------------------------------------------------------- text state
  logic [PosW-1:0]   pos_q;
  logic              have_q;
  logic [IndexW-1:0] best_q;
  logic              exceeded_q;
  logic              in_range;
  cell_ctrl_t        ctrl;
  logic [7:0]        text_f;

  assign in_range         = pos_q < TextMaxP;
  assign ctrl.advance     = in_fire & in_range;
  assign ctrl.clear       = in_fire & in_data_i.last_byte;
  assign ctrl.ignore_case = icase_q;
  assign text_f           = fold(in_data_i.text_byte, icase_q);

  // ---------------------------------------------------------------- cell chain
  logic [PATTERN_MAX-1:0] hit_d, hit_q, cell_en, tail_sel;

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    logic prev;
    if (j == 0) begin : g_head
      assign prev = 1'b1;           // a new match may start at any byte
    end else begin : g_link
      assign prev = hit_q[j-1];
    end
    assign cell_en[j]  = LenW'(j) < len_eff;
    assign tail_sel[j] = LenW'(j + 1) == len_eff;

    ssfl_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .text_i     (text_f),
      .pat_byte_i (pattern_q[8*j +: 8]),
      .enable_i   (cell_en[j]),
      .prev_i     (prev),
      .hit_d_o    (hit_d[j]),
      .hit_q_o    (hit_q[j])
    );
  end

  // Full match when the cell for the last pattern byte fires this byte.
  logic              match;
  logic [PosW-1:0]   start_pos;
  logic              have_new;
  logic [IndexW-1:0] best_new;
  logic              exceeded_new;

  assign match        = ctrl.advance & |(hit_d & tail_sel);
  assign start_pos    = pos_q - PosW'(len_eff - LenW'(1));
  assign have_new     = have_q | match;
  assign best_new     = (match && (slast_q || !have_q)) ? IndexW'(start_pos) : best_q;
  assign exceeded_new = exceeded_q | (in_fire & ~in_range);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      have_q     <= 1'b0;
      best_q     <= '0;
      exceeded_q <= 1'b0;
    end else if (ctrl.clear) begin
      pos_q      <= '0;
      have_q     <= 1'b0;
      best_q     <= '0;
      exceeded_q <= 1'b0;
    end else if (in_fire) begin
      if (in_range) begin
        pos_q <= pos_q + PosW'(1);
      end
      have_q     <= have_new;
      best_q     <= best_new;
      exceeded_q <= exceeded_new;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= in_data_i.last_byte;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.clear) begin
      out_data_q.found       <= have_new;
      out_data_q.match_index <= have_new ? best_new : '0;
      out_data_q.overflow    <= exceeded_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------- checks
  a_last_gives_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clear |=> out_valid_o)
    else $error("last byte did not produce an item");

  a_text_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clear |=> (pos_q == '0 && hit_q == '0 && !have_q && !exceeded_q))
    else $error("text state not cleared after last byte");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= TextMaxP)
    else $error("byte position past limit");

  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.found) |-> out_data_o.match_index == '0)
    else $error("index set without a match");

  a_no_cell_past_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit_d & ~cell_en) == '0)
    else $error("cell beyond pattern length matched");

endmodule
